// ----- hw/rtl/tcc_pkg.sv -----
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the text console controller.
// ----------------------------------------------------------------------------
package tcc_pkg;

   localparam int DefColumns = 80;
   localparam int DefRows    = 25;

   localparam int CellWidth  = 16;
   localparam int CharWidth  = 7;

   // register indexes of the configuration port
   localparam logic [1:0] CSR_BLINK      = 2'd0;
   localparam logic [1:0] CSR_BACKGROUND = 2'd1;
   localparam logic [1:0] CSR_TEXT_COLOR = 2'd2;

   localparam logic [3:0] TEXT_COLOR_RESET = 4'd15;

   // request kinds
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // character codes
   localparam logic [CharWidth-1:0] CH_BACKSPACE  = 7'd8;
   localparam logic [CharWidth-1:0] CH_TAB        = 7'd9;
   localparam logic [CharWidth-1:0] CH_NEWLINE    = 7'd10;
   localparam logic [CharWidth-1:0] CH_FORM_FEED  = 7'd12;
   localparam logic [CharWidth-1:0] CH_RETURN     = 7'd13;
   localparam logic [CharWidth-1:0] CH_FIRST_PRINT = 7'd32;
   localparam logic [CharWidth-1:0] CH_LAST_PRINT  = 7'd126;
   localparam logic [7:0]           CH_SPACE      = 8'd32;

   typedef enum logic [1:0] {
      SW_ALL,
      SW_COPY,
      SW_LAST
   } sweep_mode_type;

   typedef struct packed {
      logic           start;
      sweep_mode_type mode;
   } sweep_cmd_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_INIT_WAIT,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SCROLL_WAIT,
      ST_FILL_WAIT,
      ST_RESP
   } state_type;

endpackage

// ----- hw/rtl/tcc_ram.sv -----
// ----------------------------------------------------------------------------
// tcc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tcc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/tcc_sweep.sv -----
// ----------------------------------------------------------------------------
// tcc_sweep
// Address sweep unit: fills the whole screen, fills the last row, or moves
// every row up by one, one cell per cycle.
// ----------------------------------------------------------------------------
module tcc_sweep #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tcc_pkg::sweep_cmd_type                cmd,
   input  logic [tcc_pkg::CellWidth-1:0]         fill_data,
   output logic                                  busy,
   output logic                                  wr_en,
   output logic [$clog2(ROWS*COLUMNS)-1:0]       wr_addr,
   output logic [tcc_pkg::CellWidth-1:0]         wr_data,
   output logic                                  rd_en,
   output logic [$clog2(ROWS*COLUMNS)-1:0]       rd_addr,
   input  logic [tcc_pkg::CellWidth-1:0]         rd_data
);

   import tcc_pkg::*;

   localparam int CELLS     = ROWS * COLUMNS;
   localparam int AW        = $clog2(CELLS);
   localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

   logic                 active_ff, active_in;
   logic                 copy_ff, copy_in;
   logic [AW-1:0]        cnt_ff, cnt_in;
   logic [AW-1:0]        last_ff, last_in;
   logic                 pend_ff, pend_in;
   logic [AW-1:0]        pend_addr_ff;
   logic [CellWidth-1:0] fill_ff, fill_in;

   always_comb begin
      active_in = active_ff;
      copy_in   = copy_ff;
      cnt_in    = cnt_ff;
      last_in   = last_ff;
      fill_in   = fill_ff;
      pend_in   = active_ff & copy_ff;
      if (cmd.start) begin
         active_in = 1'b1;
         fill_in   = fill_data;
         case (cmd.mode)
            SW_COPY: begin
               copy_in = 1'b1;
               cnt_in  = '0;
               last_in = AW'(LAST_BASE - 1);
            end
            SW_LAST: begin
               copy_in = 1'b0;
               cnt_in  = AW'(LAST_BASE);
               last_in = AW'(CELLS - 1);
            end
            default: begin
               copy_in = 1'b0;
               cnt_in  = '0;
               last_in = AW'(CELLS - 1);
            end
         endcase
      end else if (active_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == last_ff) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      copy_ff      <= copy_in;
      cnt_ff       <= cnt_in;
      last_ff      <= last_in;
      fill_ff      <= fill_in;
      pend_addr_ff <= cnt_ff;
   end

   assign busy    = active_ff | pend_ff;
   assign rd_en   = active_ff & copy_ff;
   assign rd_addr = AW'(cnt_ff + AW'(COLUMNS));
   assign wr_en   = (active_ff & ~copy_ff) | pend_ff;
   assign wr_addr = pend_ff ? pend_addr_ff : cnt_ff;
   assign wr_data = pend_ff ? rd_data : fill_ff;

endmodule

// ----- hw/rtl/text_console_controller.sv -----
// ----------------------------------------------------------------------------
// text_console_controller
// Text screen store with cursor, character handling and cell read-back.
// ----------------------------------------------------------------------------
// A printable character or a cursor move passes from the accepted req beat
// through ST_EXEC and ST_RESP to the registered rsp_tvalid, and a cell read
// also passes through ST_READ. A newline on the last row, or a character
// that wraps past the last row, scrolls the screen through the sweep unit,
// one cell moved or blanked per cycle on the single RAM write port. A form
// feed blanks the screen through the sweep unit. After reset the screen
// store is zeroed in a clearing pass, during which req_tready is low;
// configuration writes are taken whenever reset is low.
// ----------------------------------------------------------------------------
module text_console_controller #(
   parameter int COLUMNS = tcc_pkg::DefColumns,
   parameter int ROWS    = tcc_pkg::DefRows
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // byte_value[7:0], cell_index[18:8], zero
   input  logic        req_tuser,   // kind[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cursor_row[4:0], cursor_column[11:5], cursor_position[22:12],
   // cell_value[38:23], zero
   output logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_data
);

   import tcc_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS);

   state_type            state_ff, state_in;
   logic [RW-1:0]        row_ff, row_in;
   logic [CW-1:0]        col_ff, col_in;
   logic                 kind_ff, kind_in;
   logic [CharWidth-1:0] char_ff, char_in;
   logic [10:0]          idx_ff, idx_in;
   logic                 in_range_ff, in_range_in;
   logic [CellWidth-1:0] cell_ff, cell_in;

   logic                 blink_ff;
   logic [2:0]           bg_ff;
   logic [3:0]           fg_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [39:0]          rsp_data_ff, rsp_data_in;

   logic [AW-1:0]        pos_w;
   logic [CellWidth-1:0] blank_w;
   logic                 req_fire;

   sweep_cmd_type        sw_cmd;
   logic [CellWidth-1:0] sw_fill;
   logic                 sw_busy;
   logic                 sw_wr_en;
   logic [AW-1:0]        sw_wr_addr;
   logic [CellWidth-1:0] sw_wr_data;
   logic                 sw_rd_en;
   logic [AW-1:0]        sw_rd_addr;

   logic                 top_wr_en;
   logic                 top_rd_en;
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [CellWidth-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [AW-1:0]        ram_rd_addr;
   logic [CellWidth-1:0] ram_rd_data;

   assign pos_w    = AW'(32'(row_ff) * COLUMNS + 32'(col_ff));
   assign blank_w  = {blink_ff, bg_ff, fg_ff, CH_SPACE};
   assign req_fire = req_tvalid & req_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      kind_in     = kind_ff;
      char_in     = char_ff;
      idx_in      = idx_ff;
      in_range_in = in_range_ff;
      cell_in     = cell_ff;
      sw_cmd      = '{start: 1'b0, mode: SW_ALL};
      sw_fill     = blank_w;
      top_wr_en   = 1'b0;
      top_rd_en   = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_INIT: begin
            sw_cmd   = '{start: 1'b1, mode: SW_ALL};
            sw_fill  = '0;
            state_in = ST_INIT_WAIT;
         end
         ST_INIT_WAIT: begin
            if (!sw_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               kind_in  = req_tuser;
               char_in  = req_tdata[6:0];
               idx_in   = req_tdata[18:8];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cell_in  = '0;
            state_in = ST_RESP;
            if (kind_ff == KIND_READ) begin
               top_rd_en   = 1'b1;
               in_range_in = (32'(idx_ff) < CELLS);
               state_in    = ST_READ;
            end else if (char_ff inside {[CH_FIRST_PRINT:CH_LAST_PRINT]}) begin
               top_wr_en = 1'b1;
               if (col_ff == CW'(COLUMNS - 1)) begin
                  col_in = '0;
                  if (row_ff == RW'(ROWS - 1)) begin
                     sw_cmd   = '{start: 1'b1, mode: SW_COPY};
                     state_in = ST_SCROLL_WAIT;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end else begin
               case (char_ff)
                  CH_BACKSPACE: begin
                     if (col_ff != '0) begin
                        col_in = col_ff - 1'b1;
                     end
                  end
                  CH_TAB: begin
                     if (32'(col_ff) <= COLUMNS - 8) begin
                        col_in = col_ff + CW'(4);
                     end
                  end
                  CH_NEWLINE: begin
                     col_in = '0;
                     if (row_ff == RW'(ROWS - 1)) begin
                        sw_cmd   = '{start: 1'b1, mode: SW_COPY};
                        state_in = ST_SCROLL_WAIT;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end
                  CH_FORM_FEED: begin
                     row_in   = '0;
                     col_in   = '0;
                     sw_cmd   = '{start: 1'b1, mode: SW_ALL};
                     state_in = ST_FILL_WAIT;
                  end
                  CH_RETURN: begin
                     col_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            cell_in  = in_range_ff ? ram_rd_data : '0;
            state_in = ST_RESP;
         end
         ST_SCROLL_WAIT: begin
            if (!sw_busy) begin
               sw_cmd   = '{start: 1'b1, mode: SW_LAST};
               state_in = ST_FILL_WAIT;
            end
         end
         ST_FILL_WAIT: begin
            if (!sw_busy) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, cell_ff, 11'(pos_w), 7'(col_ff), 5'(row_ff)};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         blink_ff     <= 1'b0;
         bg_ff        <= '0;
         fg_ff        <= TEXT_COLOR_RESET;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BLINK:      blink_ff <= csr_data[0];
               CSR_BACKGROUND: bg_ff    <= csr_data[2:0];
               CSR_TEXT_COLOR: fg_ff    <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      char_ff     <= char_in;
      idx_ff      <= idx_in;
      in_range_ff <= in_range_in;
      cell_ff     <= cell_in;
      rsp_data_ff <= rsp_data_in;
   end

   // sweep unit owns the RAM ports while busy
   assign ram_wr_en   = sw_wr_en | top_wr_en;
   assign ram_wr_addr = sw_busy ? sw_wr_addr : pos_w;
   assign ram_wr_data = sw_busy ? sw_wr_data
                                : {blink_ff, bg_ff, fg_ff, 1'b0, char_ff};
   assign ram_rd_en   = sw_rd_en | top_rd_en;
   assign ram_rd_addr = sw_rd_en ? sw_rd_addr : AW'(idx_ff);

   tcc_sweep #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_sweep (
      .clock     (clock),
      .reset     (reset),
      .cmd       (sw_cmd),
      .fill_data (sw_fill),
      .busy      (sw_busy),
      .wr_en     (sw_wr_en),
      .wr_addr   (sw_wr_addr),
      .wr_data   (sw_wr_data),
      .rd_en     (sw_rd_en),
      .rd_addr   (sw_rd_addr),
      .rd_data   (ram_rd_data)
   );

   tcc_ram #(
      .WIDTH (CellWidth),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ----- tb/text_console_controller_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_controller_tb
// Self-checking bench for the text console controller. Character and read
// beats are driven on the req stream, and each one is run through a local
// model of the screen store, cursor and attribute registers. Every rsp beat
// is compared field by field against the oldest predicted result. The run
// covers register settings at their extremes and random ones, and gaps on
// both streams, including a long rsp stall.
// ----------------------------------------------------------------------------
module text_console_controller_tb;
   import tcc_pkg::*;

   localparam int COLUMNS    = DefColumns;
   localparam int ROWS       = DefRows;
   localparam int CELLS      = COLUMNS * ROWS;
   localparam int CycleLimit = 6000000;
   localparam int PhaseItems = 135;
   localparam int ReportMax  = 40;

   typedef struct packed {
      logic [4:0]  cur_row;
      logic [6:0]  cur_col;
      logic [10:0] cur_pos;
      logic [15:0] cell_value;
   } console_result_type;

   class console_scoreboard;
      logic [15:0]        screen [CELLS];
      int                 row;
      int                 col;
      logic               blink;
      logic [2:0]         background;
      logic [3:0]         foreground;
      console_result_type predicted [$];
      int                 failures;

      function new();
         for (int i = 0; i < CELLS; i++) screen[i] = '0;
         row        = 0;
         col        = 0;
         blink      = 1'b0;
         background = '0;
         foreground = TEXT_COLOR_RESET;
         failures   = 0;
      endfunction

      function int pending();
         return predicted.size();
      endfunction

      function void write_register(logic [1:0] idx, logic [3:0] value);
         case (idx)
            CSR_BLINK:      blink      = value[0];
            CSR_BACKGROUND: background = value[2:0];
            CSR_TEXT_COLOR: foreground = value;
            default: ;
         endcase
      endfunction

      function logic [15:0] make_entry(logic [7:0] code);
         return {blink, background, foreground, code};
      endfunction

      function void blank_from(int first);
         for (int i = first; i < CELLS; i++) screen[i] = make_entry(CH_SPACE);
      endfunction

      function void scroll_up();
         for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen[i] = screen[i + COLUMNS];
         blank_from((ROWS - 1) * COLUMNS);
         row = ROWS - 1;
      endfunction

      function void apply_byte(logic [6:0] ch);
         if (ch >= CH_FIRST_PRINT && ch <= CH_LAST_PRINT) begin
            screen[row * COLUMNS + col] = make_entry({1'b0, ch});
            col++;
            if (col >= COLUMNS) begin
               col = 0;
               row++;
               if (row >= ROWS) scroll_up();
            end
         end else begin
            case (ch)
               CH_BACKSPACE: if (col > 0) col--;
               CH_TAB:       if (col <= COLUMNS - 8) col += 4;
               CH_NEWLINE: begin
                  col = 0;
                  if (row < ROWS - 1) row++;
                  else scroll_up();
               end
               CH_FORM_FEED: begin
                  blank_from(0);
                  row = 0;
                  col = 0;
               end
               CH_RETURN:    col = 0;
               default: ;
            endcase
         end
      endfunction

      function void note_request(logic kind, logic [7:0] value, logic [10:0] idx);
         console_result_type r;
         r.cell_value = '0;
         if (kind == KIND_CHAR) apply_byte(value[6:0]);
         else if (32'(idx) < CELLS) r.cell_value = screen[idx];
         r.cur_row = 5'(row);
         r.cur_col = 7'(col);
         r.cur_pos = 11'(row * COLUMNS + col);
         predicted.push_back(r);
      endfunction

      function void mismatch(string field, int exp_value, int act_value);
         if (failures < ReportMax)
            $error("%s expected %0d actual %0d", field, exp_value, act_value);
         failures++;
      endfunction

      function void check_response(logic [39:0] data);
         console_result_type r;
         if (predicted.size() == 0) begin
            if (failures < ReportMax) $error("rsp beat with no request outstanding");
            failures++;
            return;
         end
         r = predicted.pop_front();
         if (data[4:0] !== r.cur_row)
            mismatch("cursor_row", int'(r.cur_row), int'(data[4:0]));
         if (data[11:5] !== r.cur_col)
            mismatch("cursor_column", int'(r.cur_col), int'(data[11:5]));
         if (data[22:12] !== r.cur_pos)
            mismatch("cursor_position", int'(r.cur_pos), int'(data[22:12]));
         if (data[38:23] !== r.cell_value)
            mismatch("cell_value", int'(r.cell_value), int'(data[38:23]));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // byte_value[7:0], cell_index[18:8], zero
   logic        req_tuser;   // kind[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // cursor_row[4:0], cursor_column[11:5], cursor_position[22:12],
   // cell_value[38:23], zero
   logic [39:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [3:0]  csr_data;

   console_scoreboard sb;
   int send_idle   = 0;
   int stall_pct   = 0;
   int hold_token  = 0;
   int hold_seen   = 0;
   int hold_left   = 0;
   int item_count  = 0;
   int cycle_count = 0;

   text_console_controller i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // rsp side: long hold-off on request, random stalls otherwise
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen  <= hold_token;
         hold_left  <= 400;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_register(csr_index, csr_data);
         if (req_tvalid && req_tready) sb.note_request(req_tuser, req_tdata[7:0], req_tdata[18:8]);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      end
   end

   function automatic logic [7:0] with_high(input logic [6:0] code);
      logic [7:0] b;
      b    = {1'b0, code};
      b[7] = 1'($urandom_range(0, 1));
      return b;
   endfunction

   function automatic logic [7:0] printable_byte();
      return with_high(7'($urandom_range(CH_FIRST_PRINT, CH_LAST_PRINT)));
   endfunction

   task automatic send_item(input logic kind, input logic [7:0] value, input logic [10:0] idx);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'b0, idx, value};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      item_count++;
   endtask

   task automatic send_char(input logic [7:0] value);
      send_item(KIND_CHAR, value, 11'($urandom_range(0, 2047)));
   endtask

   task automatic send_read(input logic [10:0] idx);
      send_item(KIND_READ, 8'($urandom_range(0, 255)), idx);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [3:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_attributes(input logic blink, input logic [2:0] bg, input logic [3:0] fg);
      write_csr(CSR_BLINK, {3'b0, blink});
      write_csr(CSR_BACKGROUND, {1'b0, bg});
      write_csr(CSR_TEXT_COLOR, fg);
   endtask

   task automatic random_sequence();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         n = $urandom_range(0, 99);
         if (n < 30) send_read(11'($urandom_range(0, CELLS - 1)));
         else if (n < 35) send_read(11'($urandom_range(CELLS, 2047)));
         else if (n < 37) send_char(with_high(CH_FORM_FEED));
         else send_char(8'($urandom_range(0, 255)));
      end else if (pick < 62) begin
         // line of text, mostly closed by a newline
         n = $urandom_range(1, 12);
         repeat (n) send_char(printable_byte());
         n = $urandom_range(0, 9);
         if (n < 2) send_char(with_high(CH_RETURN));
         if (n < 8) send_char(with_high(CH_NEWLINE));
      end else if (pick < 72) begin
         // tab toward the right edge, then text that may wrap
         repeat ($urandom_range(14, 20)) send_char(with_high(CH_TAB));
         repeat ($urandom_range(1, 8)) send_char(printable_byte());
      end else if (pick < 82) begin
         repeat ($urandom_range(1, 4)) send_read(11'($urandom_range(0, CELLS - 1)));
      end else if (pick < 90) begin
         repeat ($urandom_range(1, 6)) send_char(with_high(CH_BACKSPACE));
         repeat ($urandom_range(0, 3)) send_char(printable_byte());
      end else begin
         repeat ($urandom_range(1, 6)) send_char(with_high(CH_NEWLINE));
      end
   endtask

   initial begin
      logic paused;
      sb         = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = KIND_CHAR;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_BLINK;
      csr_data   = '0;
      paused     = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // field extremes and every byte class under reset attributes
      send_read(11'd0);
      send_read(11'(CELLS - 1));
      send_read(11'h7ff);
      send_char({1'b0, CH_FIRST_PRINT});
      send_char({1'b0, CH_LAST_PRINT});
      send_char(8'ha1);
      send_char(8'h7f);
      send_char(8'h00);
      send_char(8'hff);
      send_char(8'h1f);
      send_char({1'b0, CH_BACKSPACE});
      send_char({1'b0, CH_TAB});
      send_char({1'b0, CH_RETURN});
      send_char({1'b0, CH_BACKSPACE});
      send_char({1'b0, CH_NEWLINE});
      send_char({1'b1, CH_NEWLINE});
      send_char(8'h0b);
      send_read(11'd0);
      send_read(11'd1);
      send_read(11'd2);
      send_char({1'b0, CH_FORM_FEED});
      send_read(11'd0);
      send_read(11'(CELLS - 1));

      for (int phase = 0; phase < 4; phase++) begin
         wait_drained();
         case (phase)
            0: set_attributes(1'b1, 3'd7, 4'd0);
            1: set_attributes(1'b0, 3'd0, 4'd15);
            default: set_attributes(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                                    4'($urandom_range(0, 15)));
         endcase
         case (phase)
            0: begin send_idle = 0;  stall_pct <= 0;  end
            1: begin send_idle = 62; stall_pct <= 0;  end
            2: begin send_idle = 0;  stall_pct <= 62; end
            default: begin send_idle = 31; stall_pct <= 31; end
         endcase
         if (phase == 0) hold_token <= hold_token + 1;
         item_count = 0;
         while (item_count < PhaseItems) begin
            random_sequence();
            if (phase == 1 && !paused && item_count >= 60) begin
               wait_drained();
               paused = 1'b1;
            end
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/tcc_pkg.sv
hw/rtl/tcc_ram.sv
hw/rtl/tcc_sweep.sv
hw/rtl/text_console_controller.sv
tb/text_console_controller_tb.sv
